@@ src/vem_pkg.sv @@
// Shared types, constants and the logarithm table of the vortex energy and momentum core.
`timescale 1ns / 1ps
`default_nettype none
package vem_pkg;

   localparam int MAX_POINTS     = 64;
   localparam int LOG_TABLE_BITS = 8;

   localparam int AddrW       = $clog2(MAX_POINTS);
   localparam int CountW      = $clog2(MAX_POINTS + 1);
   localparam int CoordW      = 16;
   localparam int ProdW       = 2 * CoordW;
   localparam int ArgW        = 35;
   localparam int ArgMagW     = ArgW - 1;
   localparam int PosW        = $clog2(ArgMagW);
   localparam int LnFracW     = 24;
   localparam int LnW         = 30;
   localparam int TermProdW   = ProdW + LnW;
   localparam int TermW       = TermProdW - LnFracW;
   localparam int EnergyW     = 44;
   localparam int MomW        = 37;
   localparam int PointCountW = 7;
   localparam int TableSize   = 1 << LOG_TABLE_BITS;
   localparam int ScaleW      = 21;
   localparam int SplitW      = EnergyW / 2;
   localparam int ScaleProdW  = SplitW + ScaleW;
   localparam int ScaleSumW   = EnergyW + LnFracW;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueFillW  = $clog2(QueueDepth + 1);
   localparam int OneExp      = 30;

   localparam logic signed [LnW-1:0]   LN2_Q24    = 30'sd11629080;
   localparam logic [ScaleW-1:0]       INV4PI_Q24 = 21'd1335088;
   localparam logic signed [ArgW-1:0]  ArgOne     = 35'sh0_8000_0000;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic signed [CoordW-1:0] g;
   } point_type;

   typedef struct packed {
      point_type         pt;
      logic              last;
      logic              drop;
      logic [CountW-1:0] slot;
   } item_type;

   typedef struct packed {
      logic                    valid;
      logic                    coincident;
      logic signed [TermW-1:0] term;
   } pair_result_type;

   typedef struct packed {
      logic idle;
      logic pair_busy;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_UPDATE,
      ST_ABS,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_COMBINE
   } back_state_type;

   typedef logic [LnFracW-1:0] log_table_type [TableSize];

   // Bit-serial unsigned division, evaluated only while the table is built.
   function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((n >> i) & 64'd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   // ln(1 + m / 2^LOG_TABLE_BITS) in Q.24 through the odd atanh series.
   function automatic longint unsigned log_entry(longint unsigned m);
      longint unsigned den;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned k;
      den  = (64'd1 << (LOG_TABLE_BITS + 1)) + m;
      t    = udiv(m << 32, den);
      t2   = (t * t) >> 32;
      term = t;
      sum  = 0;
      k    = 1;
      for (int it = 0; it < 64; it++) begin
         if (term != 0) begin
            sum  = sum + udiv(term, k);
            term = (term * t2) >> 32;
            k    = k + 2;
         end
      end
      return sum >> 7;
   endfunction

   function automatic log_table_type build_log_table();
      log_table_type tbl;
      for (int i = 0; i < TableSize; i++) begin
         tbl[i] = LnFracW'(log_entry(longint'(i)));
      end
      return tbl;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

   function automatic logic signed [EnergyW-1:0] sat_energy(logic signed [EnergyW:0] v);
      if (v[EnergyW] != v[EnergyW-1]) begin
         return v[EnergyW] ? {1'b1, {(EnergyW-1){1'b0}}} : {1'b0, {(EnergyW-1){1'b1}}};
      end
      return v[EnergyW-1:0];
   endfunction

   function automatic logic signed [MomW-1:0] sat_mom(logic signed [MomW:0] v);
      if (v[MomW] != v[MomW-1]) begin
         return v[MomW] ? {1'b1, {(MomW-1){1'b0}}} : {1'b0, {(MomW-1){1'b1}}};
      end
      return v[MomW-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/vortex_energy_momentum_core.sv @@
// Top level of the point vortex energy and momentum core.
// A word that finds k points already stored is paired with each of them in the back end.
// A closing word (last set) passes the energy scaling states before its result appears.
// The walk reads one stored point per cycle from the single read port of the point store.
// The front queue takes two words while the back end is busy; full rises after that.
// Synchronous reset clears all sums, counts, flags and queues; the point store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module vortex_energy_momentum_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic signed [vem_pkg::CoordW-1:0]    req_px,
   input  wire logic signed [vem_pkg::CoordW-1:0]    req_py,
   input  wire logic signed [vem_pkg::CoordW-1:0]    req_pz,
   input  wire logic signed [vem_pkg::CoordW-1:0]    req_circulation,
   input  wire logic                                 req_last,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic signed [vem_pkg::EnergyW-1:0]        rsp_energy,
   output logic signed [vem_pkg::MomW-1:0]           rsp_mom_x,
   output logic signed [vem_pkg::MomW-1:0]           rsp_mom_y,
   output logic signed [vem_pkg::MomW-1:0]           rsp_mom_z,
   output logic [vem_pkg::PointCountW-1:0]           rsp_point_count,
   output logic                                      rsp_coincident_flag,
   output logic                                      rsp_overflow_flag
);
   import vem_pkg::*;

   point_type        req_pt;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;
   logic             ram_re;
   logic [AddrW-1:0] ram_raddr;
   logic             ram_we;
   logic [AddrW-1:0] ram_waddr;
   point_type        ram_wdata;
   logic [$bits(point_type)-1:0] ram_rdata;
   back_status_type  status;

   assign req_pt.x = req_px;
   assign req_pt.y = req_py;
   assign req_pt.z = req_pz;
   assign req_pt.g = req_circulation;

   vem_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .pt      (req_pt),
      .last    (req_last),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   vem_ram #(
      .Width ($bits(point_type)),
      .Depth (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   vem_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .ram_re              (ram_re),
      .ram_raddr           (ram_raddr),
      .ram_we              (ram_we),
      .ram_waddr           (ram_waddr),
      .ram_wdata           (ram_wdata),
      .ram_rdata           (point_type'(ram_rdata)),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_energy          (rsp_energy),
      .rsp_mom_x           (rsp_mom_x),
      .rsp_mom_y           (rsp_mom_y),
      .rsp_mom_z           (rsp_mom_z),
      .rsp_point_count     (rsp_point_count),
      .rsp_coincident_flag (rsp_coincident_flag),
      .rsp_overflow_flag   (rsp_overflow_flag),
      .status              (status)
   );

   // A stored point is written only after every pair term of its walk has been added.
   assert property (@(posedge clock) disable iff (reset) ram_we |-> !status.pair_busy)
      else $error("point store written while pair terms are in flight");

   // The back end takes a new word only with an empty pair pipeline.
   assert property (@(posedge clock) disable iff (reset) status.idle |-> !status.pair_busy)
      else $error("pair pipeline busy while the back end is idle");

   // Walk reads and store writes never share a cycle.
   assert property (@(posedge clock) disable iff (reset) ram_re |-> !ram_we)
      else $error("point store read and written in the same cycle");

endmodule
`default_nettype wire

@@ src/vem_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vem_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/vem_front.sv @@
// Front end: accepts words, classifies them as stored or dropped, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module vem_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire vem_pkg::point_type pt,
   input  wire logic              last,
   output logic                   q_valid,
   output vem_pkg::item_type      q_item,
   input  wire logic              q_pop
);
   import vem_pkg::*;

   item_type               entry_ff [QueueDepth];
   item_type               entry_in;
   logic [QueuePtrW-1:0]   wptr_ff, wptr_in;
   logic [QueuePtrW-1:0]   rptr_ff, rptr_in;
   logic [QueueFillW-1:0]  fill_ff, fill_in;
   logic [CountW-1:0]      count_ff, count_in;
   logic                   accept;
   logic                   take;

   assign full    = (fill_ff == QueueFillW'(QueueDepth));
   assign q_valid = (fill_ff != '0);
   assign q_item  = entry_ff[rptr_ff];
   assign accept  = push && !full;
   assign take    = q_pop && q_valid;

   always_comb begin
      entry_in.pt   = pt;
      entry_in.last = last;
      entry_in.drop = (count_ff == CountW'(MAX_POINTS));
      entry_in.slot = count_ff;

      count_in = count_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
         end else if (!entry_in.drop) begin
            count_in = count_ff + CountW'(1);
         end
      end

      wptr_in = accept ? wptr_ff + QueuePtrW'(1) : wptr_ff;
      rptr_in = take ? rptr_ff + QueuePtrW'(1) : rptr_ff;
      fill_in = fill_ff;
      if (accept && !take) begin
         fill_in = fill_ff + QueueFillW'(1);
      end else if (take && !accept) begin
         fill_in = fill_ff - QueueFillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

@@ src/vem_pair.sv @@
// Pair term pipeline: dot product, log argument, table logarithm and weighted term.
`timescale 1ns / 1ps
`default_nettype none
module vem_pair (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               issue,
   input  wire vem_pkg::point_type cur,
   input  wire vem_pkg::point_type stored,
   output vem_pkg::pair_result_type result,
   output logic                    busy
);
   import vem_pkg::*;

   logic [7:0] valid_ff;

   logic signed [ProdW-1:0]   xx_ff, yy_ff, zz_ff, gg_a_ff;
   logic signed [ProdW-1:0]   xx_in, yy_in, zz_in, gg_in;
   logic signed [ArgW-1:0]    dot;
   logic signed [ArgW-1:0]    arg_in, arg_ff;
   logic                      coin_in;
   logic                      coin_b_ff, coin_c_ff, coin_d_ff, coin_e_ff, coin_f_ff, coin_g_ff;
   logic signed [ProdW-1:0]   gg_b_ff, gg_c_ff, gg_d_ff, gg_e_ff;
   logic [ArgMagW-1:0]        mag_c_ff;
   logic [PosW-1:0]           pos_in, pos_c_ff, pos_d_ff;
   logic [PosW-1:0]           shamt;
   logic [ArgMagW-1:0]        norm;
   logic [LOG_TABLE_BITS-1:0] m_in, m_ff;
   logic signed [PosW:0]      pexp;
   logic signed [LnW+PosW:0]  ln_sum;
   logic signed [LnW-1:0]     ln_ff;
   logic signed [TermProdW-1:0] prod_in, prod_ff;
   logic signed [TermProdW-1:0] biased;
   logic signed [TermW-1:0]   term_ff;

   always_comb begin
      xx_in = cur.x * stored.x;
      yy_in = cur.y * stored.y;
      zz_in = cur.z * stored.z;
      gg_in = cur.g * stored.g;

      dot     = ArgW'(xx_ff) + ArgW'(yy_ff) + ArgW'(zz_ff);
      arg_in  = ArgOne - (dot <<< 1);
      coin_in = arg_in[ArgW-1] || (arg_in == '0);

      pos_in = '0;
      for (int b = 0; b < ArgMagW; b++) begin
         if (arg_ff[b]) begin
            pos_in = PosW'(b);
         end
      end

      shamt = PosW'(ArgMagW - 1) - pos_c_ff;
      norm  = mag_c_ff << shamt;
      m_in  = norm[ArgMagW-2 -: LOG_TABLE_BITS];

      pexp   = $signed({1'b0, pos_d_ff}) - (PosW + 1)'(OneExp);
      ln_sum = pexp * LN2_Q24
             + $signed({{(LnW + PosW + 1 - LnFracW){1'b0}}, LOG_TABLE[m_ff]});

      prod_in = gg_e_ff * ln_ff;
      biased  = prod_ff + (prod_ff[TermProdW-1] ?
                TermProdW'({LnFracW{1'b1}}) : TermProdW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[6:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      xx_ff     <= xx_in;
      yy_ff     <= yy_in;
      zz_ff     <= zz_in;
      gg_a_ff   <= gg_in;
      arg_ff    <= arg_in;
      coin_b_ff <= coin_in;
      gg_b_ff   <= gg_a_ff;
      pos_c_ff  <= pos_in;
      mag_c_ff  <= arg_ff[ArgMagW-1:0];
      coin_c_ff <= coin_b_ff;
      gg_c_ff   <= gg_b_ff;
      m_ff      <= m_in;
      pos_d_ff  <= pos_c_ff;
      coin_d_ff <= coin_c_ff;
      gg_d_ff   <= gg_c_ff;
      ln_ff     <= ln_sum[LnW-1:0];
      coin_e_ff <= coin_d_ff;
      gg_e_ff   <= gg_d_ff;
      prod_ff   <= prod_in;
      coin_f_ff <= coin_e_ff;
      term_ff   <= biased[TermProdW-1:LnFracW];
      coin_g_ff <= coin_f_ff;
   end

   assign result.valid      = valid_ff[7];
   assign result.coincident = coin_g_ff;
   assign result.term       = term_ff;
   assign busy              = |valid_ff;

endmodule
`default_nettype wire

@@ src/vem_back.sv @@
// Back end: walks stored points, accumulates energy and momentum, and emits the result word.
`timescale 1ns / 1ps
`default_nettype none
module vem_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire vem_pkg::item_type             q_item,
   output logic                               q_pop,
   output logic                               ram_re,
   output logic [vem_pkg::AddrW-1:0]          ram_raddr,
   output logic                               ram_we,
   output logic [vem_pkg::AddrW-1:0]          ram_waddr,
   output vem_pkg::point_type                 ram_wdata,
   input  wire vem_pkg::point_type            ram_rdata,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic signed [vem_pkg::EnergyW-1:0] rsp_energy,
   output logic signed [vem_pkg::MomW-1:0]    rsp_mom_x,
   output logic signed [vem_pkg::MomW-1:0]    rsp_mom_y,
   output logic signed [vem_pkg::MomW-1:0]    rsp_mom_z,
   output logic [vem_pkg::PointCountW-1:0]    rsp_point_count,
   output logic                               rsp_coincident_flag,
   output logic                               rsp_overflow_flag,
   output vem_pkg::back_status_type           status
);
   import vem_pkg::*;

   back_state_type          state_ff, state_in;
   item_type                cur_ff, cur_in;
   logic [AddrW-1:0]        walk_ff, walk_in;
   logic signed [EnergyW-1:0] energy_ff, energy_in;
   logic signed [MomW-1:0]  mom_x_ff, mom_x_in, mom_y_ff, mom_y_in, mom_z_ff, mom_z_in;
   logic [CountW-1:0]       count_ff, count_in;
   logic                    coin_ff, coin_in;
   logic                    ovf_ff, ovf_in;
   logic signed [ProdW-1:0] mprod_x_ff, mprod_y_ff, mprod_z_ff;
   logic [EnergyW-1:0]      mag_ff, mag_in;
   logic [ScaleProdW-1:0]   scale_lo_ff, scale_lo_in, scale_hi_ff, scale_hi_in;
   logic [ScaleSumW-1:0]    scale_sum;
   logic [EnergyW-1:0]      scaled_ff, scaled_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_load;
   logic signed [EnergyW-1:0] out_energy_ff;
   logic signed [MomW-1:0]  out_mom_x_ff, out_mom_y_ff, out_mom_z_ff;
   logic [PointCountW-1:0]  out_count_ff;
   logic                    out_coin_ff, out_ovf_ff;
   logic                    issue;
   pair_result_type         pair_res;
   logic                    pair_busy;

   vem_pair u_pair (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .cur    (cur_ff.pt),
      .stored (ram_rdata),
      .result (pair_res),
      .busy   (pair_busy)
   );

   assign scale_sum = (ScaleSumW'(scale_hi_ff) << SplitW) + ScaleSumW'(scale_lo_ff);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      energy_in    = energy_ff;
      mom_x_in     = mom_x_ff;
      mom_y_in     = mom_y_ff;
      mom_z_in     = mom_z_ff;
      count_in     = count_ff;
      coin_in      = coin_ff;
      ovf_in       = ovf_ff;
      mag_in       = mag_ff;
      scale_lo_in  = scale_lo_ff;
      scale_hi_in  = scale_hi_ff;
      scaled_in    = scaled_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_load     = 1'b0;
      q_pop        = 1'b0;
      issue        = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = walk_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff.slot[AddrW-1:0];
      ram_wdata    = cur_ff.pt;

      if (pair_res.valid) begin
         if (pair_res.coincident) begin
            coin_in = 1'b1;
         end else begin
            energy_in = sat_energy((EnergyW + 1)'(energy_ff) - (EnergyW + 1)'(pair_res.term));
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cur_in  = q_item;
               walk_in = '0;
               if (q_item.drop) begin
                  state_in = ST_UPDATE;
               end else if (q_item.slot == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            ram_re  = 1'b1;
            issue   = 1'b1;
            walk_in = walk_ff + AddrW'(1);
            if (CountW'(walk_ff) + CountW'(1) == cur_ff.slot) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pair_busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cur_ff.drop) begin
               ovf_in = 1'b1;
            end else begin
               mom_x_in = sat_mom((MomW + 1)'(mom_x_ff) + (MomW + 1)'(mprod_x_ff));
               mom_y_in = sat_mom((MomW + 1)'(mom_y_ff) + (MomW + 1)'(mprod_y_ff));
               mom_z_in = sat_mom((MomW + 1)'(mom_z_ff) + (MomW + 1)'(mprod_z_ff));
               ram_we   = 1'b1;
               count_in = cur_ff.slot + CountW'(1);
            end
            state_in = cur_ff.last ? ST_ABS : ST_IDLE;
         end
         ST_ABS: begin
            mag_in   = energy_ff[EnergyW-1] ? EnergyW'(-energy_ff) : EnergyW'(energy_ff);
            state_in = ST_SCALE_LO;
         end
         ST_SCALE_LO: begin
            scale_lo_in = ScaleProdW'(mag_ff[SplitW-1:0]) * ScaleProdW'(INV4PI_Q24);
            state_in    = ST_SCALE_HI;
         end
         ST_SCALE_HI: begin
            scale_hi_in = ScaleProdW'(mag_ff[EnergyW-1:SplitW]) * ScaleProdW'(INV4PI_Q24);
            state_in    = ST_COMBINE;
         end
         ST_COMBINE: begin
            scaled_in = scale_sum[LnFracW +: EnergyW];
            if (!out_valid_ff || rsp_pop) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               energy_in    = '0;
               mom_x_in     = '0;
               mom_y_in     = '0;
               mom_z_in     = '0;
               count_in     = '0;
               coin_in      = 1'b0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         energy_ff    <= '0;
         mom_x_ff     <= '0;
         mom_y_ff     <= '0;
         mom_z_ff     <= '0;
         count_ff     <= '0;
         coin_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         energy_ff    <= energy_in;
         mom_x_ff     <= mom_x_in;
         mom_y_ff     <= mom_y_in;
         mom_z_ff     <= mom_z_in;
         count_ff     <= count_in;
         coin_ff      <= coin_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      walk_ff     <= walk_in;
      mprod_x_ff  <= cur_ff.pt.g * cur_ff.pt.x;
      mprod_y_ff  <= cur_ff.pt.g * cur_ff.pt.y;
      mprod_z_ff  <= cur_ff.pt.g * cur_ff.pt.z;
      mag_ff      <= mag_in;
      scale_lo_ff <= scale_lo_in;
      scale_hi_ff <= scale_hi_in;
      scaled_ff   <= scaled_in;
      if (out_load) begin
         out_energy_ff <= energy_ff[EnergyW-1] ? -$signed(scaled_in) : $signed(scaled_in);
         out_mom_x_ff  <= mom_x_ff;
         out_mom_y_ff  <= mom_y_ff;
         out_mom_z_ff  <= mom_z_ff;
         out_count_ff  <= PointCountW'(count_ff);
         out_coin_ff   <= coin_ff;
         out_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_energy          = out_energy_ff;
   assign rsp_mom_x           = out_mom_x_ff;
   assign rsp_mom_y           = out_mom_y_ff;
   assign rsp_mom_z           = out_mom_z_ff;
   assign rsp_point_count     = out_count_ff;
   assign rsp_coincident_flag = out_coin_ff;
   assign rsp_overflow_flag   = out_ovf_ff;
   assign status.idle         = (state_ff == ST_IDLE);
   assign status.pair_busy    = pair_busy;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the vortex energy and momentum core with its own bit-exact predictor.
`timescale 1ns / 1ps
module tb_top;
   import vem_pkg::*;

   localparam longint CycleLimit = 2000000;

   typedef struct {
      logic signed [CoordW-1:0] x, y, z, g;
      logic last;
   } vortex_word;

   typedef struct {
      logic [EnergyW-1:0] energy;
      logic [MomW-1:0] mx, my, mz;
      logic [PointCountW-1:0] count;
      logic coincident, overflow;
   } sums_word;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [CoordW-1:0] req_px = '0, req_py = '0, req_pz = '0, req_circulation = '0;
   logic req_last = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [EnergyW-1:0] rsp_energy;
   logic signed [MomW-1:0] rsp_mom_x, rsp_mom_y, rsp_mom_z;
   logic [PointCountW-1:0] rsp_point_count;
   logic rsp_coincident_flag, rsp_overflow_flag;

   vortex_energy_momentum_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   vortex_word pending_words[$];
   sums_word expected_sums[$];
   longint cycles = 0;
   int errors = 0;
   int words_sent = 0;
   int hold_left = 0;
   bit hold_done = 0;

   longint unsigned ln_frac[TableSize];
   longint signed vx[MAX_POINTS], vy[MAX_POINTS], vz[MAX_POINTS], vg[MAX_POINTS];
   int npoints = 0;
   longint signed energy_acc = 0;
   longint signed mom_acc[3] = '{0, 0, 0};
   bit saw_coincident = 0, saw_overflow = 0;

   function automatic longint signed clamp(longint signed v, int bits);
      longint signed hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint signed scale24(longint signed v, longint unsigned c);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag * c) >> 24;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint signed ln_q30(longint unsigned a);
      int p;
      longint unsigned m;
      p = 0;
      for (int b = 0; b <= 40; b++)
         if ((a >> b) & 1) p = b;
      m = (((a - (64'd1 << p)) << LOG_TABLE_BITS) >> p) & (TableSize - 1);
      return longint'(p - 30) * 11629080 + longint'(ln_frac[m]);
   endfunction

   task automatic absorb_point(vortex_word w);
      longint signed dot, arg, term;
      sums_word s;
      if (npoints >= MAX_POINTS) begin
         saw_overflow = 1;
      end else begin
         for (int j = 0; j < npoints; j++) begin
            dot = w.x * vx[j] + w.y * vy[j] + w.z * vz[j];
            arg = 2 * ((64'sd1 <<< 30) - dot);
            if (arg <= 0) begin
               saw_coincident = 1;
            end else begin
               term = scale24(w.g * vg[j] * ln_q30(arg), 1);
               energy_acc = clamp(energy_acc - term, EnergyW);
            end
         end
         mom_acc[0] = clamp(mom_acc[0] + w.g * w.x, MomW);
         mom_acc[1] = clamp(mom_acc[1] + w.g * w.y, MomW);
         mom_acc[2] = clamp(mom_acc[2] + w.g * w.z, MomW);
         vx[npoints] = w.x; vy[npoints] = w.y; vz[npoints] = w.z; vg[npoints] = w.g;
         npoints++;
      end
      if (w.last) begin
         s.energy = EnergyW'(scale24(energy_acc, 1335088));
         s.mx = MomW'(mom_acc[0]);
         s.my = MomW'(mom_acc[1]);
         s.mz = MomW'(mom_acc[2]);
         s.count = PointCountW'(npoints);
         s.coincident = saw_coincident;
         s.overflow = saw_overflow;
         expected_sums.push_back(s);
         npoints = 0;
         energy_acc = 0;
         mom_acc = '{0, 0, 0};
         saw_coincident = 0;
         saw_overflow = 0;
      end
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         errors++;
         $display("mismatch %s: got %h expected %h", field, got, want);
      end
   endtask

   function automatic bit idle_now();
      if (cycles >= 10000 && cycles < 20000) return 0;
      return $urandom_range(99) < 34;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL vortex_energy_momentum_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            absorb_point(pending_words.pop_front());
            words_sent++;
         end
         if (!(req_push && req_full)) begin
            if (pending_words.size() > 0 && !idle_now()) begin
               req_px <= pending_words[0].x;
               req_py <= pending_words[0].y;
               req_pz <= pending_words[0].z;
               req_circulation <= pending_words[0].g;
               req_last <= pending_words[0].last;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && words_sent >= 600) begin
            hold_done <= 1;
            hold_left <= 3000;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      sums_word s;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_sums.size() == 0) begin
               errors++;
               $display("mismatch: result word with none expected");
            end else begin
               s = expected_sums.pop_front();
               report("energy", $unsigned(rsp_energy), s.energy);
               report("mom_x", $unsigned(rsp_mom_x), s.mx);
               report("mom_y", $unsigned(rsp_mom_y), s.my);
               report("mom_z", $unsigned(rsp_mom_z), s.mz);
               report("point_count", rsp_point_count, s.count);
               report("coincident_flag", rsp_coincident_flag, s.coincident);
               report("overflow_flag", rsp_overflow_flag, s.overflow);
            end
         end
         if ((!hold_done && words_sent >= 600) || hold_left > 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !idle_now();
         end
      end
   end

   function automatic logic signed [CoordW-1:0] rand_field();
      logic signed [CoordW-1:0] v;
      v = CoordW'($urandom);
      return v >>> $urandom_range(0, 4);
   endfunction

   task automatic queue_word(logic signed [CoordW-1:0] x, y, z, g, logic last);
      vortex_word w;
      w.x = x; w.y = y; w.z = z; w.g = g; w.last = last;
      pending_words.push_back(w);
   endtask

   initial begin
      longint unsigned den, t, t2, term, sum, k;
      int total, size;
      vortex_word w;
      for (int m = 0; m < TableSize; m++) begin
         den = (64'd1 << (LOG_TABLE_BITS + 1)) + m;
         t = (longint'(m) << 32) / den;
         t2 = (t * t) >> 32;
         term = t; sum = 0; k = 1;
         while (term != 0) begin
            sum += term / k;
            term = (term * t2) >> 32;
            k += 2;
         end
         ln_frac[m] = sum >> 7;
      end

      queue_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      queue_word(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0);
      queue_word(16'sh7fff, -16'sh8000, 16'sh0000, 16'sh7fff, 1);
      queue_word(-16'sh8000, 0, 0, 16'sh1000, 0);
      queue_word(-16'sh8000, 0, 0, 16'sh1000, 1);
      queue_word(16'sh4000, 16'sh0000, 16'sh0000, 16'sh1000, 1);
      queue_word(0, 0, 16'sh7fff, 0, 0);
      queue_word(0, 0, -16'sh8000, -16'sh8000, 0);
      queue_word(16'sh0001, 16'sh0001, 16'sh0001, 16'sh7fff, 0);
      queue_word(16'sh5a82, 16'sh5a82, 0, -16'sh8000, 1);
      queue_word(16'sh7fff, 0, 0, 16'sh2000, 0);
      queue_word(16'sh7ffe, 16'sh0100, 0, 16'sh2000, 1);
      for (int i = 0; i < 66; i++)
         queue_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, i == 65);

      total = 0;
      while (total < 2000) begin
         size = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
         for (int i = 0; i < size; i++) begin
            if (i > 0 && $urandom_range(9) == 0) begin
               w = pending_words[$];
            end else begin
               w.x = rand_field(); w.y = rand_field(); w.z = rand_field();
               w.g = rand_field();
            end
            queue_word(w.x, w.y, w.z, w.g, i == size - 1);
         end
         total += size;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && expected_sums.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_sums.size() == 0)
         $display("PASS vortex_energy_momentum_core");
      else
         $display("FAIL vortex_energy_momentum_core");
      $finish;
   end
endmodule
